@@ sv/pla_pkg.sv @@
// ---------------------------------------------------------------------------
// Priority lock arbiter package
// Shared field widths, operation and status codes, and controller states.
// ---------------------------------------------------------------------------
package pla_pkg;

    localparam int ID_W      = 6;
    localparam int PRIO_IN_W = 8;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 5;

    typedef enum logic
    {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STAT_GRANTED      = 3'd0,
        STAT_QUEUED       = 3'd1,
        STAT_HANDED_OFF   = 3'd2,
        STAT_FREED        = 3'd3,
        STAT_QUEUE_FULL   = 3'd4,
        STAT_RELEASE_FREE = 3'd5
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_PLACE
    } state_t;

endpackage

@@ sv/priority_lock_arbiter.sv @@
// ---------------------------------------------------------------------------
// Priority lock arbiter
// Hardware lock with a wait queue kept in priority order, first in, first
// out among equal priorities, and direct handoff to the head waiter.
// ---------------------------------------------------------------------------
// Channel   Transfer when          Payload
// request   start && !busy         operation, requester_id, request_priority
// result    done (one cycle)       status, granted_id, waiting_count
//
// Grants, frees, rejections and an acquire into an empty queue are answered
// from the idle state. A handoff goes through S_POP after one memory read of
// the head waiter. A queued acquire shifts each lower waiter down one slot in
// S_SCAN via the single memory write port; S_PLACE puts it at the head if all move.
// After reset the lock is free and the queue is empty; no result is stalled.
// ---------------------------------------------------------------------------
module priority_lock_arbiter import pla_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 operation,
    input  logic [ID_W-1:0]      requester_id,
    input  logic [PRIO_IN_W-1:0] request_priority,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [ID_W-1:0]      granted_id,
    output logic [COUNT_W-1:0]   waiting_count
);

    localparam int PW     = (PRIORITY_BITS < PRIO_IN_W) ? PRIORITY_BITS : PRIO_IN_W;
    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DATA_W = ID_W + PW;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    pla_ctrl
    #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    )
    u_ctrl
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .requester_id     (requester_id),
        .request_priority (request_priority),
        .done             (done),
        .status           (status),
        .granted_id       (granted_id),
        .waiting_count    (waiting_count),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata)
    );

    pla_wait_ram
    #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ sv/pla_wait_ram.sv @@
// ---------------------------------------------------------------------------
// Priority lock arbiter wait queue memory
// Simple dual-port memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module pla_wait_ram
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 14
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/pla_ctrl.sv @@
// ---------------------------------------------------------------------------
// Priority lock arbiter controller
// Holds the lock flag, the queue head and fill count, and sequences the
// sorted insertion and the head removal through the wait queue memory.
// ---------------------------------------------------------------------------
module pla_ctrl import pla_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    operation,
    input  logic [ID_W-1:0]                         requester_id,
    input  logic [PRIO_IN_W-1:0]                    request_priority,
    output logic                                    done,
    output logic [STATUS_W-1:0]                     status,
    output logic [ID_W-1:0]                         granted_id,
    output logic [COUNT_W-1:0]                      waiting_count,
    output logic                                    ram_we,
    output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] ram_waddr,
    output logic [ID_W+((PRIORITY_BITS < PRIO_IN_W) ? PRIORITY_BITS : PRIO_IN_W)-1:0]
                                                    ram_wdata,
    output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] ram_raddr,
    input  logic [ID_W+((PRIORITY_BITS < PRIO_IN_W) ? PRIORITY_BITS : PRIO_IN_W)-1:0]
                                                    ram_rdata
);

    localparam int PW     = (PRIORITY_BITS < PRIO_IN_W) ? PRIORITY_BITS : PRIO_IN_W;
    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    state_t             state_reg,     state_next;
    logic               lock_busy_reg, lock_busy_next;
    logic [IDX_W-1:0]   head_reg,      head_next;
    logic [CNT_W-1:0]   total_reg,     total_next;
    logic [CNT_W-1:0]   slot_reg,      slot_next;
    logic [ID_W-1:0]    req_id_reg,    req_id_next;
    logic [PW-1:0]      req_prio_reg,  req_prio_next;
    logic               done_reg,      done_next;
    logic [STATUS_W-1:0] status_reg,   status_next;
    logic [ID_W-1:0]    gid_reg,       gid_next;
    logic [COUNT_W-1:0] count_reg,     count_next;

    logic [PW-1:0]      rd_prio;
    logic [ID_W-1:0]    rd_id;
    logic [PW-1:0]      in_prio;

    // The queue is a ring: the entry at rank k sits at head + k, wrapped.
    function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign rd_prio = ram_rdata[PW-1:0];
    assign rd_id   = ram_rdata[PW +: ID_W];
    assign in_prio = request_priority[PW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lock_busy_reg <= 1'b0;
            head_reg      <= '0;
            total_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lock_busy_reg <= lock_busy_next;
            head_reg      <= head_next;
            total_reg     <= total_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        req_id_reg   <= req_id_next;
        req_prio_reg <= req_prio_next;
        status_reg   <= status_next;
        gid_reg      <= gid_next;
        count_reg    <= count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        lock_busy_next = lock_busy_reg;
        head_next      = head_reg;
        total_next     = total_reg;
        slot_next      = slot_reg;
        req_id_next    = req_id_reg;
        req_prio_next  = req_prio_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        gid_next       = gid_reg;
        count_next     = count_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_ACQUIRE)
                    begin
                        if (!lock_busy_reg)
                        begin
                            lock_busy_next = 1'b1;
                            done_next      = 1'b1;
                            status_next    = STAT_GRANTED;
                            gid_next       = requester_id;
                            count_next     = COUNT_W'(total_reg);
                        end
                        else if (total_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_QUEUE_FULL;
                            gid_next    = '0;
                            count_next  = COUNT_W'(total_reg);
                        end
                        else if (total_reg == '0)
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = head_reg;
                            ram_wdata   = {requester_id, in_prio};
                            total_next  = CNT_W'(1);
                            done_next   = 1'b1;
                            status_next = STAT_QUEUED;
                            gid_next    = '0;
                            count_next  = COUNT_W'(1);
                        end
                        else
                        begin
                            req_id_next   = requester_id;
                            req_prio_next = in_prio;
                            slot_next     = total_reg;
                            ram_raddr     = slot_addr(head_reg, total_reg - CNT_W'(1));
                            state_next    = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (!lock_busy_reg)
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_RELEASE_FREE;
                            gid_next    = '0;
                            count_next  = COUNT_W'(total_reg);
                        end
                        else if (total_reg == '0)
                        begin
                            lock_busy_next = 1'b0;
                            done_next      = 1'b1;
                            status_next    = STAT_FREED;
                            gid_next       = '0;
                            count_next     = '0;
                        end
                        else
                        begin
                            ram_raddr  = head_reg;
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_POP:
            begin
                head_next   = slot_addr(head_reg, CNT_W'(1));
                total_next  = total_reg - CNT_W'(1);
                done_next   = 1'b1;
                status_next = STAT_HANDED_OFF;
                gid_next    = rd_id;
                count_next  = COUNT_W'(total_reg - CNT_W'(1));
                state_next  = S_IDLE;
            end

            S_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_addr(head_reg, slot_reg);
                if (rd_prio >= req_prio_reg)
                begin
                    ram_wdata   = {req_id_reg, req_prio_reg};
                    total_next  = total_reg + CNT_W'(1);
                    done_next   = 1'b1;
                    status_next = STAT_QUEUED;
                    gid_next    = '0;
                    count_next  = COUNT_W'(total_reg + CNT_W'(1));
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_wdata = ram_rdata;
                    slot_next = slot_reg - CNT_W'(1);
                    if (slot_reg == CNT_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ram_raddr = slot_addr(head_reg, slot_reg - CNT_W'(2));
                    end
                end
            end

            S_PLACE:
            begin
                ram_we      = 1'b1;
                ram_waddr   = slot_addr(head_reg, slot_reg);
                ram_wdata   = {req_id_reg, req_prio_reg};
                total_next  = total_reg + CNT_W'(1);
                done_next   = 1'b1;
                status_next = STAT_QUEUED;
                gid_next    = '0;
                count_next  = COUNT_W'(total_reg + CNT_W'(1));
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_id    = gid_reg;
    assign waiting_count = count_reg;

endmodule

@@ tb/priority_lock_arbiter_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Priority lock arbiter testbench
// Drives acquire and release requests in bursts with random gaps, keeps its
// own model of the lock and the sorted wait queue, and checks every result
// transfer field by field against the expected outcome.
// ---------------------------------------------------------------------------
module priority_lock_arbiter_tb;
    import pla_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int PRIORITY_BITS  = 8;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 24;

    typedef struct {
        op_t                  op;
        logic [ID_W-1:0]      id;
        logic [PRIO_IN_W-1:0] prio;
        bit                   drain_first;
    } lock_request_t;

    typedef struct {
        status_t              status;
        logic [ID_W-1:0]      granted_id;
        logic [COUNT_W-1:0]   waiting_count;
    } lock_outcome_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 operation = 1'b0;
    logic [ID_W-1:0]      requester_id = '0;
    logic [PRIO_IN_W-1:0] request_priority = '0;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      granted_id;
    logic [COUNT_W-1:0]   waiting_count;

    lock_request_t        request_q[$];
    lock_outcome_t        outcome_q[$];
    int unsigned          issued_count = 0;
    int unsigned          taken_count = 0;
    int unsigned          burst_left = 1;
    int unsigned          gap_left = 0;
    int unsigned          idle_cycles = 0;
    int unsigned          error_count = 0;

    bit                   lock_held;
    logic [PRIO_IN_W-1:0] waiter_prio [QUEUE_DEPTH];
    logic [ID_W-1:0]      waiter_ident [QUEUE_DEPTH];
    int unsigned          waiter_cnt;

    priority_lock_arbiter
    #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    )
    DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .requester_id     (requester_id),
        .request_priority (request_priority),
        .done             (done),
        .status           (status),
        .granted_id       (granted_id),
        .waiting_count    (waiting_count)
    );

    always #5 clk = ~clk;

    function automatic lock_outcome_t arbitrate(op_t op, logic [ID_W-1:0] id,
                                                logic [PRIO_IN_W-1:0] prio);
        lock_outcome_t res;
        int unsigned   pos;
        res.granted_id = '0;
        if (op == OP_ACQUIRE)
        begin
            if (!lock_held)
            begin
                lock_held      = 1'b1;
                res.status     = STAT_GRANTED;
                res.granted_id = id;
            end
            else if (waiter_cnt >= QUEUE_DEPTH)
            begin
                res.status = STAT_QUEUE_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < waiter_cnt && waiter_prio[pos] >= prio)
                    pos++;
                for (int k = waiter_cnt; k > pos; k--)
                begin
                    waiter_prio[k]  = waiter_prio[k-1];
                    waiter_ident[k] = waiter_ident[k-1];
                end
                waiter_prio[pos]  = prio;
                waiter_ident[pos] = id;
                waiter_cnt++;
                res.status = STAT_QUEUED;
            end
        end
        else
        begin
            if (!lock_held)
            begin
                res.status = STAT_RELEASE_FREE;
            end
            else if (waiter_cnt == 0)
            begin
                lock_held  = 1'b0;
                res.status = STAT_FREED;
            end
            else
            begin
                res.granted_id = waiter_ident[0];
                for (int k = 1; k < waiter_cnt; k++)
                begin
                    waiter_prio[k-1]  = waiter_prio[k];
                    waiter_ident[k-1] = waiter_ident[k];
                end
                waiter_cnt--;
                res.status = STAT_HANDED_OFF;
            end
        end
        res.waiting_count = waiter_cnt[COUNT_W-1:0];
        return res;
    endfunction

    task automatic add_request(op_t op, int unsigned id, int unsigned prio, bit drain_first);
        lock_request_t req;
        req.op          = op;
        req.id          = id[ID_W-1:0];
        req.prio        = prio[PRIO_IN_W-1:0];
        req.drain_first = drain_first;
        request_q.push_back(req);
    endtask

    // Requests change on the falling edge; a request whose transfer has not
    // happened yet is held unchanged.
    always @(negedge clk)
    begin
        if (rst_n && taken_count == issued_count)
        begin
            if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (request_q.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (request_q[0].drain_first && (outcome_q.size() != 0 || busy))
            begin
                start <= 1'b0;
            end
            else
            begin
                start            <= 1'b1;
                operation        <= request_q[0].op;
                requester_id     <= request_q[0].id;
                request_priority <= request_q[0].prio;
                request_q.pop_front();
                issued_count     <= issued_count + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, status %0d",
                             $time, status);
                    error_count++;
                end
                else
                begin
                    if (status !== outcome_q[0].status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, outcome_q[0].status, status);
                        error_count++;
                    end
                    if (granted_id !== outcome_q[0].granted_id)
                    begin
                        $display("%0t: granted_id expected %0d, got %0d",
                                 $time, outcome_q[0].granted_id, granted_id);
                        error_count++;
                    end
                    if (waiting_count !== outcome_q[0].waiting_count)
                    begin
                        $display("%0t: waiting_count expected %0d, got %0d",
                                 $time, outcome_q[0].waiting_count, waiting_count);
                        error_count++;
                    end
                    outcome_q.pop_front();
                end
            end
            if (start && !busy)
            begin
                outcome_q.push_back(arbitrate(op_t'(operation), requester_id,
                                              request_priority));
                taken_count <= taken_count + 1;
            end
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned  phase_left;
        bit           filling;
        op_t          op;
        int unsigned  prio;
        int unsigned  roll;
        int unsigned  directed_prio [QUEUE_DEPTH];
        directed_prio = '{0, 255, 255, 128, 1, 254, 128, 0, 64, 200, 255, 7, 128, 32, 100, 3};

        lock_held  = 1'b0;
        waiter_cnt = 0;

        // A release of a free lock, a grant, a full queue with ties at both
        // extremes of priority, a rejected acquire and then handoffs.
        add_request(OP_RELEASE, 63, 255, 1'b0);
        add_request(OP_ACQUIRE, 63, 255, 1'b0);
        for (int k = 0; k < QUEUE_DEPTH; k++)
            add_request(OP_ACQUIRE, k * 5 + 1, directed_prio[k], 1'b0);
        add_request(OP_ACQUIRE, 0, 255, 1'b0);
        for (int k = 0; k < 4; k++)
            add_request(OP_RELEASE, $urandom_range(0, 63), $urandom_range(0, 255), 1'b0);

        phase_left = 0;
        filling    = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (phase_left == 0)
            begin
                filling    = !filling;
                phase_left = $urandom_range(8, 60);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 10)
                op = op_t'($urandom_range(0, 1));
            else if (filling)
                op = (roll < 80) ? OP_ACQUIRE : OP_RELEASE;
            else
                op = (roll < 35) ? OP_ACQUIRE : OP_RELEASE;
            case ($urandom_range(0, 3))
                0: prio = $urandom_range(0, 1) ? 255 : 0;
                1: prio = $urandom_range(0, 3) * 85;
                default: prio = $urandom_range(0, 255);
            endcase
            add_request(op, $urandom_range(0, 63), prio,
                        (i == 0) || (i == RANDOM_ITEMS / 2) || ($urandom_range(0, 199) == 0));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_q.size() != 0 || taken_count != issued_count)
            @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/pla_pkg.sv
sv/pla_wait_ram.sv
sv/pla_ctrl.sv
sv/priority_lock_arbiter.sv
tb/priority_lock_arbiter_tb.sv
